### rtl/tqm_pkg.sv
package tqm_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MS_W      = 24;
  localparam int TIME_W    = 32;

  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // command codes
  localparam logic [2:0] CMD_ARM      = 3'd0;
  localparam logic [2:0] CMD_CHANGE   = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_STOP_ALL = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef struct packed {
    logic [2:0]      command;
    logic [3:0]      slot;
    logic [MS_W-1:0] delay_ms;
    logic [MS_W-1:0] period_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      fired_slot;
    logic [MS_W-1:0] remaining_ms;
    logic            none_pending;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [MS_W-1:0]   period;
  } slot_entry_t;

  typedef struct packed {
    logic             clear;
    logic             cmp_vld;
    logic             due_only;
    logic             active;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] delta;
    logic [MS_W-1:0]   period;
  } scan_res_t;

endpackage

### rtl/tqm_slot_mem.sv
module tqm_slot_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tqm_pkg::IDX_W-1:0] waddr_i,
  input  tqm_pkg::slot_entry_t      wdata_i,
  input  logic [tqm_pkg::IDX_W-1:0] raddr_i,
  output tqm_pkg::slot_entry_t      rdata_o
);
  import tqm_pkg::*;

  slot_entry_t mem_q [NUM_SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tqm_scanner.sv
module tqm_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tqm_pkg::scan_ctl_t         ctl_i,
  input  tqm_pkg::slot_entry_t       entry_i,
  input  logic [tqm_pkg::TIME_W-1:0] now_i,
  output tqm_pkg::scan_res_t         res_o
);
  import tqm_pkg::*;

  logic              found_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] delta_q;
  logic [MS_W-1:0]   period_q;

  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] key;
  logic [TIME_W-1:0] best_key;
  logic              due;
  logic              cand;
  logic              take;

  // signed distance mapped to an unsigned order
  assign delta    = entry_i.expiry - now_i;
  assign key      = delta ^ {1'b1, {(TIME_W-1){1'b0}}};
  assign best_key = delta_q ^ {1'b1, {(TIME_W-1){1'b0}}};
  assign due      = (delta == '0) || delta[TIME_W-1];
  assign cand     = ctl_i.cmp_vld && ctl_i.active && (!ctl_i.due_only || due);
  // strict compare keeps the lower index on ties
  assign take     = cand && (!found_q || (key < best_key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      idx_q    <= ctl_i.idx;
      delta_q  <= delta;
      period_q <= entry_i.period;
    end
  end

  assign res_o.found  = found_q;
  assign res_o.idx    = idx_q;
  assign res_o.delta  = delta_q;
  assign res_o.period = period_q;

endmodule

### rtl/timeout_queue_manager_top.sv
// timer slot table with millisecond ticks, one-shot and periodic slots
// command channel: a word on cmd_i is taken at a clock edge with start_i high
//   and busy_o low
// result channel: each result word sits on result_o for one cycle with
//   result_valid_o high; the receiver cannot stall, so every word is final
//   when shown and last marks the final word of a command
// arm, change, stop, stop all and unknown commands: the result appears in the
//   cycle after the accepting edge and busy_o stays low
// query: one pass over the slot memory, busy_o high until the report appears
// tick: one pass per fired slot plus a closing pass that finds nothing due;
//   the single read port of the slot memory sets the pass length
// each fired word is held back one pass so that last can be set on it
// reset clears the time counter and all active bits; slot memory contents
//   are only read for active slots and need no clearing
module timeout_queue_manager_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tqm_pkg::cmd_t    cmd_i,
  output logic             busy_o,
  output tqm_pkg::result_t result_o,
  output logic             result_valid_o
);
  import tqm_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 tick_q, tick_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]     pend_slot_q, pend_slot_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  result_t              res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic                 accept;
  logic                 in_range;
  logic [IDX_W-1:0]     slot_idx;
  logic                 scan_clear;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  slot_entry_t          mem_wdata;
  slot_entry_t          mem_rdata;

  scan_ctl_t            scan_ctl;
  scan_res_t            scan_res;

  logic                 best_due;
  logic [MS_W-1:0]      best_rem;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_range = 32'(cmd_i.slot) < 32'(NUM_SLOTS);
  assign slot_idx = IDX_W'(cmd_i.slot);

  // remaining time of the earliest slot, saturated
  assign best_due = (scan_res.delta == '0) || scan_res.delta[TIME_W-1];
  always_comb begin
    if (best_due) begin
      best_rem = '0;
    end else if (scan_res.delta > TIME_W'(MS_MAX)) begin
      best_rem = MS_MAX;
    end else begin
      best_rem = scan_res.delta[MS_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    now_d       = now_q;
    active_d    = active_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    scan_clear  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = slot_idx;
    mem_wdata.expiry = now_q + TIME_W'(cmd_i.delay_ms);
    mem_wdata.period = cmd_i.period_ms;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_vld_d          = 1'b1;
          res_d.kind         = KIND_ACK;
          res_d.fired_slot   = cmd_i.slot;
          res_d.remaining_ms = '0;
          res_d.none_pending = 1'b0;
          res_d.last         = 1'b1;
          unique case (cmd_i.command)
            CMD_ARM: begin
              if (in_range) begin
                mem_we             = 1'b1;
                active_d[slot_idx] = 1'b1;
              end else begin
                res_d.kind = KIND_ERROR;
              end
            end
            CMD_CHANGE: begin
              if (in_range && active_q[slot_idx]) begin
                mem_we = 1'b1;
              end else begin
                res_d.kind = KIND_ERROR;
              end
            end
            CMD_STOP: begin
              if (in_range) begin
                active_d[slot_idx] = 1'b0;
              end else begin
                res_d.kind = KIND_ERROR;
              end
            end
            CMD_STOP_ALL: begin
              active_d         = '0;
              res_d.fired_slot = '0;
            end
            CMD_TICK: begin
              res_vld_d  = 1'b0;
              now_d      = now_q + 1'b1;
              tick_d     = 1'b1;
              pend_vld_d = 1'b0;
              cnt_d      = '0;
              scan_clear = 1'b1;
              state_d    = ST_SCAN;
            end
            CMD_QUERY: begin
              res_vld_d  = 1'b0;
              tick_d     = 1'b0;
              cnt_d      = '0;
              scan_clear = 1'b1;
              state_d    = ST_SCAN;
            end
            default: begin
              // unknown command: plain acknowledge
              res_d.fired_slot = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        // compare of the final entry completes here
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        res_d.remaining_ms = '0;
        res_d.none_pending = 1'b0;
        res_d.fired_slot   = 4'(pend_slot_q);
        res_d.kind         = KIND_FIRED;
        if (tick_q) begin
          if (scan_res.found) begin
            // release the held fired word, it is not the final one
            res_vld_d   = pend_vld_q;
            res_d.last  = 1'b0;
            pend_vld_d  = 1'b1;
            pend_slot_d = scan_res.idx;
            if (scan_res.period != '0) begin
              mem_we           = 1'b1;
              mem_waddr        = scan_res.idx;
              mem_wdata.expiry = now_q + TIME_W'(scan_res.period);
              mem_wdata.period = scan_res.period;
            end else begin
              active_d[scan_res.idx] = 1'b0;
            end
            cnt_d      = '0;
            scan_clear = 1'b1;
            state_d    = ST_SCAN;
          end else begin
            res_vld_d  = 1'b1;
            res_d.last = 1'b1;
            if (!pend_vld_q) begin
              // nothing was due on this tick
              res_d.kind       = KIND_ACK;
              res_d.fired_slot = '0;
            end
            pend_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else begin
          res_vld_d  = 1'b1;
          res_d.kind = KIND_REPORT;
          res_d.last = 1'b1;
          if (scan_res.found) begin
            res_d.fired_slot   = 4'(scan_res.idx);
            res_d.remaining_ms = best_rem;
          end else begin
            res_d.fired_slot   = '0;
            res_d.none_pending = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      tick_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      now_q      <= '0;
      active_q   <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cmp_vld_q  <= (state_q == ST_SCAN);
      tick_q     <= tick_d;
      pend_vld_q <= pend_vld_d;
      now_q      <= now_d;
      active_q   <= active_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cnt_q;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  tqm_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  // read data of entry cmp_idx_q arrives in the cycle after its address, together with cmp_idx_q
  assign scan_ctl.clear    = scan_clear;
  assign scan_ctl.cmp_vld  = cmp_vld_q;
  assign scan_ctl.due_only = tick_q;
  assign scan_ctl.active   = active_q[cmp_idx_q];
  assign scan_ctl.idx      = cmp_idx_q;

  tqm_scanner u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .entry_i (mem_rdata),
    .now_i   (now_q),
    .res_o   (scan_res)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

### verif/tb_timeout_queue_manager_top.sv
module tb_timeout_queue_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tqm_pkg::*;

  // codes 6 and 7 have no meaning in the block and must come back as a plain ack
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // one scan pass over the slot memory, used for the drain at the end
  localparam int PASS_CYCLES = NUM_SLOTS + 2;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  cmd_t    cmd_i;
  logic    busy_o;
  result_t result_o;
  logic    result_valid_o;

  timeout_queue_manager_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // clock, 10 ns period
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // timer table mirror: time counter, active bits, expiry and period per slot
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] clock_ms = '0;
  logic              armed [NUM_SLOTS] = '{default: 1'b0};
  logic [TIME_W-1:0] expiry_at [NUM_SLOTS];
  logic [MS_W-1:0]   period_of [NUM_SLOTS];

  // results of the word being predicted, then the whole backlog in order
  result_t word_results[$];
  result_t pending_results[$];

  // per sent word: a result typed in by hand, or nothing
  typedef struct packed {
    logic    typed;
    result_t res;
  } typed_word_t;
  typed_word_t typed_results[$];

  int words_sent  = 0;
  int words_taken = 0;
  int fail_count  = 0;
  int idle_pct    = 0;

  function automatic result_t make_result(logic [1:0] kind, logic [3:0] slot,
                                          logic [MS_W-1:0] rem, logic none);
    result_t r;
    r.kind         = kind;
    r.fired_slot   = slot;
    r.remaining_ms = rem;
    r.none_pending = none;
    r.last         = 1'b0;
    return r;
  endfunction

  // a slot is due when expiry minus now, read as signed, is zero or below
  function automatic logic slot_due(int i);
    logic [TIME_W-1:0] d;
    d = expiry_at[i] - clock_ms;
    return (d == '0) || d[TIME_W-1];
  endfunction

  // earliest active slot, ties to the lower index, -1 when none qualifies
  function automatic int earliest_slot(logic due_only);
    int                best;
    logic [TIME_W-1:0] best_key;
    logic [TIME_W-1:0] key;
    best     = -1;
    best_key = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i] && (!due_only || slot_due(i))) begin
        // flip the sign bit so that signed distances order as unsigned
        key = (expiry_at[i] - clock_ms) ^ {1'b1, {(TIME_W-1){1'b0}}};
        if (best < 0 || key < best_key) begin
          best     = i;
          best_key = key;
        end
      end
    end
    return best;
  endfunction

  // apply one command word to the mirror and collect the results it causes
  task automatic timer_table_step(input cmd_t w);
    int                f;
    logic [TIME_W-1:0] d;
    logic [MS_W-1:0]   rem;
    result_t           r;
    word_results.delete();
    case (w.command)
      CMD_ARM, CMD_CHANGE: begin
        if (int'(w.slot) >= NUM_SLOTS || (w.command == CMD_CHANGE && !armed[w.slot])) begin
          word_results.push_back(make_result(KIND_ERROR, w.slot, '0, 1'b0));
        end else begin
          armed[w.slot]     = 1'b1;
          expiry_at[w.slot] = clock_ms + TIME_W'(w.delay_ms);
          period_of[w.slot] = w.period_ms;
          word_results.push_back(make_result(KIND_ACK, w.slot, '0, 1'b0));
        end
      end
      CMD_STOP: begin
        if (int'(w.slot) >= NUM_SLOTS) begin
          word_results.push_back(make_result(KIND_ERROR, w.slot, '0, 1'b0));
        end else begin
          armed[w.slot] = 1'b0;
          word_results.push_back(make_result(KIND_ACK, w.slot, '0, 1'b0));
        end
      end
      CMD_STOP_ALL: begin
        for (int i = 0; i < NUM_SLOTS; i++) armed[i] = 1'b0;
        word_results.push_back(make_result(KIND_ACK, '0, '0, 1'b0));
      end
      CMD_TICK: begin
        clock_ms = clock_ms + 1'b1;
        f = earliest_slot(1'b1);
        while (f >= 0 && word_results.size() < NUM_SLOTS) begin
          // periodic slots come back at now plus period, one-shots are freed
          if (period_of[f] != '0) expiry_at[f] = clock_ms + TIME_W'(period_of[f]);
          else armed[f] = 1'b0;
          word_results.push_back(make_result(KIND_FIRED, 4'(f), '0, 1'b0));
          f = earliest_slot(1'b1);
        end
        if (word_results.size() == 0)
          word_results.push_back(make_result(KIND_ACK, '0, '0, 1'b0));
      end
      CMD_QUERY: begin
        f = earliest_slot(1'b0);
        if (f < 0) begin
          word_results.push_back(make_result(KIND_REPORT, '0, '0, 1'b1));
        end else begin
          d   = expiry_at[f] - clock_ms;
          rem = '0;
          if (!slot_due(f)) rem = (d > TIME_W'(MS_MAX)) ? MS_MAX : d[MS_W-1:0];
          word_results.push_back(make_result(KIND_REPORT, 4'(f), rem, 1'b0));
        end
      end
      default: begin
        word_results.push_back(make_result(KIND_ACK, '0, '0, 1'b0));
      end
    endcase
    r = word_results.pop_back();
    r.last = 1'b1;
    word_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // monitor: results first, then the word accepted at this same edge
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t     want;
    typed_word_t tw;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d slot %0d",
                 result_o.kind, result_o.fired_slot);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", want.kind, result_o.kind);
          compare_field("fired_slot", want.fired_slot, result_o.fired_slot);
          compare_field("remaining_ms", want.remaining_ms, result_o.remaining_ms);
          compare_field("none_pending", want.none_pending, result_o.none_pending);
          compare_field("last", want.last, result_o.last);
        end
      end
      if (start_i && !busy_o) begin
        // mirror always advances; a hand typed result replaces its output
        timer_table_step(cmd_i);
        tw = typed_results.pop_front();
        if (tw.typed) begin
          want      = tw.res;
          want.last = 1'b1;
          pending_results.push_back(want);
        end else begin
          foreach (word_results[i]) pending_results.push_back(word_results[i]);
        end
        words_taken <= words_taken + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // driver: called at a falling edge, returns at the falling edge after the
  // accepting rising edge; start stays high across back to back words
  // ---------------------------------------------------------------------
  task automatic send_word(input cmd_t w, input logic typed, input result_t res);
    typed_word_t tw;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    tw.typed = typed;
    tw.res   = res;
    typed_results.push_back(tw);
    words_sent++;
    start_i <= 1'b1;
    cmd_i   <= w;
    do @(negedge clk_i); while (words_taken < words_sent);
  endtask

  function automatic cmd_t make_word(logic [2:0] command, logic [3:0] slot,
                                     logic [MS_W-1:0] delay, logic [MS_W-1:0] period);
    cmd_t w;
    w.command   = command;
    w.slot      = slot;
    w.delay_ms  = delay;
    w.period_ms = period;
    return w;
  endfunction

  // mostly short delays so that timers really fire, now and then any value
  function automatic logic [MS_W-1:0] random_ms();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) return MS_W'($urandom_range(6));
    if (pick < 95) return MS_W'($urandom());
    return MS_MAX;
  endfunction

  function automatic cmd_t random_word();
    int unsigned     pick;
    logic [2:0]      command;
    logic [MS_W-1:0] period;
    pick = $urandom_range(99);
    if (pick < 25)      command = CMD_ARM;
    else if (pick < 35) command = CMD_CHANGE;
    else if (pick < 43) command = CMD_STOP;
    else if (pick < 46) command = CMD_STOP_ALL;
    else if (pick < 80) command = CMD_TICK;
    else if (pick < 95) command = CMD_QUERY;
    else if (pick < 98) command = CMD_SPARE_6;
    else                command = CMD_SPARE_7;
    period = ($urandom_range(2) == 0) ? '0 : random_ms();
    return make_word(command, 4'($urandom_range(15)), random_ms(), period);
  endfunction

  // ---------------------------------------------------------------------
  // directed table: word plus, where obvious, the single result typed in
  // ---------------------------------------------------------------------
  typedef struct packed {
    cmd_t    word;
    logic    typed;
    result_t res;
  } table_row_t;
  table_row_t directed_rows[$];

  task automatic add_row(input logic [2:0] command, input logic [3:0] slot,
                         input logic [MS_W-1:0] delay, input logic [MS_W-1:0] period);
    table_row_t row;
    row.word  = make_word(command, slot, delay, period);
    row.typed = 1'b0;
    row.res   = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed_row(input logic [2:0] command, input logic [3:0] slot,
                               input logic [MS_W-1:0] delay, input logic [MS_W-1:0] period,
                               input logic [1:0] kind, input logic [3:0] fslot,
                               input logic [MS_W-1:0] rem, input logic none);
    table_row_t row;
    row.word  = make_word(command, slot, delay, period);
    row.typed = 1'b1;
    row.res   = make_result(kind, fslot, rem, none);
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    int burst_span;
    int phase_items;
    int phase_pct [4];
    start_i = 1'b0;
    cmd_i   = '0;
    rst_ni  = 1'b0;

    //            cmd           slot  delay   period  kind         slot  rem  none
    add_typed_row(CMD_QUERY,    4'd0, '0,     '0,     KIND_REPORT, 4'd0, '0,  1'b1);
    add_typed_row(CMD_TICK,     4'd0, '0,     '0,     KIND_ACK,    4'd0, '0,  1'b0);
    // change of an inactive slot is refused
    add_typed_row(CMD_CHANGE,   4'd3, 24'd5,  24'd5,  KIND_ERROR,  4'd3, '0,  1'b0);
    // stop of an inactive slot is only acknowledged
    add_typed_row(CMD_STOP,     4'd5, '0,     '0,     KIND_ACK,    4'd5, '0,  1'b0);
    add_typed_row(CMD_SPARE_6,  4'd9, MS_MAX, MS_MAX, KIND_ACK,    4'd0, '0,  1'b0);
    add_typed_row(CMD_SPARE_7,  4'd15, '0,    '0,     KIND_ACK,    4'd0, '0,  1'b0);
    add_typed_row(CMD_ARM,      4'd15, MS_MAX, MS_MAX, KIND_ACK,   4'd15, '0, 1'b0);
    // zero delay: due right away
    add_typed_row(CMD_ARM,      4'd0, '0,     '0,     KIND_ACK,    4'd0, '0,  1'b0);
    add_typed_row(CMD_QUERY,    4'd0, '0,     '0,     KIND_REPORT, 4'd0, '0,  1'b0);
    add_typed_row(CMD_TICK,     4'd0, '0,     '0,     KIND_FIRED,  4'd0, '0,  1'b0);
    add_row(CMD_ARM,    4'd1, 24'd2, 24'd3);
    add_row(CMD_ARM,    4'd2, 24'd2, 24'd0);
    // re-arm of an active slot and change of an active slot
    add_row(CMD_ARM,    4'd1, 24'd1, 24'd3);
    add_row(CMD_CHANGE, 4'd2, 24'd1, 24'd0);
    add_row(CMD_QUERY,  4'd0, '0,    '0);
    // equal expiry: lower index fires first
    add_row(CMD_TICK,   4'd0, '0,    '0);
    add_row(CMD_ARM,    4'd4, 24'd0, 24'd1);
    add_row(CMD_ARM,    4'd9, 24'd0, 24'd0);
    add_row(CMD_STOP,   4'd9, '0,    '0);
    add_row(CMD_TICK,   4'd0, '0,    '0);
    add_row(CMD_QUERY,  4'd0, '0,    '0);
    add_typed_row(CMD_STOP_ALL, 4'd7, '0,     '0,     KIND_ACK,    4'd0, '0,  1'b0);
    add_typed_row(CMD_QUERY,    4'd0, '0,     '0,     KIND_REPORT, 4'd0, '0,  1'b1);
    add_typed_row(CMD_TICK,     4'd0, '0,     '0,     KIND_ACK,    4'd0, '0,  1'b0);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part runs without idling
    idle_pct = 0;
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

    // phases: no idling, sender mostly idle, receiver stall phase (the
    // receiver cannot stall, so it runs flat out), then light idling
    phase_pct = '{0, 88, 0, 7};
    for (int p = 0; p < 4; p++) begin
      idle_pct    = phase_pct[p];
      phase_items = 0;
      while (phase_items < 36) begin
        if ($urandom_range(11) == 0) begin
          // arm 4 to NUM_SLOTS slots due now or next tick, then tick: up to the
          // widest burst of fired words, ties broken by index
          burst_span = $urandom_range(4, NUM_SLOTS);
          for (int s = 0; s < burst_span; s++)
            send_word(make_word(CMD_ARM, 4'(s), MS_W'($urandom_range(1)),
                                ($urandom_range(1) == 0) ? '0 : MS_W'($urandom_range(1, 3))),
                      1'b0, '0);
          send_word(make_word(CMD_TICK, '0, '0, '0), 1'b0, '0);
          send_word(make_word(CMD_TICK, '0, '0, '0), 1'b0, '0);
          phase_items += burst_span + 2;
        end else begin
          send_word(random_word(), 1'b0, '0);
          phase_items++;
        end
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // a stray word after the last expected one would show up within a pass
    repeat (2 * PASS_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("tb_timeout_queue_manager_top OK");
    end else begin
      $display("tb_timeout_queue_manager_top NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("tb_timeout_queue_manager_top NOT OK");
    $finish;
  end

endmodule
